// ----- hdl/tbg_pkg.sv -----
`default_nettype none

package tbg_pkg;

   localparam int COUNT_W    = 7;
   localparam int INDEX_W    = 6;
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 32;
   localparam int NUM_COMP   = 4;
   localparam int LIMIT_W    = 20;
   localparam int PRODUCED_W = 21;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   localparam logic [LIMIT_W-1:0]    LIMIT_RESET  = LIMIT_W'(100000);
   localparam logic [CSR_ADDR_W-1:0] ADDR_LIMIT   = CSR_ADDR_W'(0);
   localparam logic                  FUNC_GEN     = 1'b0;
   localparam logic                  FUNC_RESEED  = 1'b1;

   localparam logic [WORD_W-1:0] MASK_C0 = 32'hFFFF_FFFE;
   localparam logic [WORD_W-1:0] MASK_C1 = 32'hFFFF_FFF8;
   localparam logic [WORD_W-1:0] MASK_C2 = 32'hFFFF_FFF0;
   localparam logic [WORD_W-1:0] MASK_C3 = 32'hFFFF_FF80;

   typedef struct packed {
      logic reseed;
      logic start;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic out_free;
      logic last_step;
   } status_type;

endpackage

`default_nettype wire

// ----- hdl/tbg_ctrl.sv -----
`default_nettype none

module tbg_ctrl
   import tbg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_func,
   input  wire status_type status,
   output cmd_type         cmd,
   output logic            req_stall
);

   typedef enum logic {IDLE, GEN} state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_RESEED) begin
                  cmd.reseed = 1'b1;
               end else if (!status.count_zero) begin
                  cmd.start = 1'b1;
                  state_in  = GEN;
               end
            end
         end
         GEN: begin
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.last_step) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != IDLE);

endmodule

`default_nettype wire

// ----- hdl/tbg_datapath.sv -----
`default_nettype none

module tbg_datapath
   import tbg_pkg::*;
#(
   parameter int MAX_REQUEST_BYTES = 64
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output status_type              status,
   input  wire logic [COUNT_W-1:0] req_byte_count,
   input  wire logic [WORD_W-1:0]  req_mix_word0,
   input  wire logic [WORD_W-1:0]  req_mix_word1,
   input  wire logic [WORD_W-1:0]  req_mix_word2,
   input  wire logic [WORD_W-1:0]  req_mix_word3,
   input  wire logic [WORD_W-1:0]  req_entropy0,
   input  wire logic [WORD_W-1:0]  req_entropy1,
   input  wire logic [WORD_W-1:0]  req_entropy2,
   input  wire logic [WORD_W-1:0]  req_entropy3,
   input  wire logic               req_entropy_valid,
   input  wire logic [LIMIT_W-1:0] limit,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [BYTE_W-1:0]       rsp_byte_value,
   output logic [INDEX_W-1:0]      rsp_buffer_index,
   output logic                    rsp_last_byte,
   output logic                    rsp_reseed_due
);

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_REQUEST_BYTES);
   localparam logic [PRODUCED_W-1:0] PRODUCED_MAX = '1;

   logic [WORD_W-1:0]     comp_ff [NUM_COMP];
   logic [WORD_W-1:0]     comp_step [NUM_COMP];
   logic [WORD_W-1:0]     c0_mixed;
   logic [WORD_W-1:0]     word_ff;
   logic [WORD_W-1:0]     word_new;
   logic [WORD_W-1:0]     word_cur;
   logic [1:0]            pos_ff;
   logic [COUNT_W-1:0]    left_ff;
   logic [COUNT_W-1:0]    count_clamped;
   logic [COUNT_W-1:0]    idx;
   logic                  due_ff;
   logic [PRODUCED_W-1:0] produced_ff;
   logic [PRODUCED_W:0]   produced_sum;
   logic                  rsp_valid_ff;
   logic [BYTE_W-1:0]     byte_sel;

   always_comb begin
      comp_step[0] = ((comp_ff[0] & MASK_C0) << 18)
                   ^ (((comp_ff[0] << 6) ^ comp_ff[0]) >> 13);
      comp_step[1] = ((comp_ff[1] & MASK_C1) << 2)
                   ^ (((comp_ff[1] << 2) ^ comp_ff[1]) >> 27);
      comp_step[2] = ((comp_ff[2] & MASK_C2) << 7)
                   ^ (((comp_ff[2] << 13) ^ comp_ff[2]) >> 21);
      comp_step[3] = ((comp_ff[3] & MASK_C3) << 13)
                   ^ (((comp_ff[3] << 3) ^ comp_ff[3]) >> 12);
      word_new = comp_step[0] ^ comp_step[1] ^ comp_step[2] ^ comp_step[3];
      word_cur = (pos_ff == 2'd0) ? word_new : word_ff;
      case (pos_ff)
         2'd0:    byte_sel = word_cur[31:24];
         2'd1:    byte_sel = word_cur[23:16];
         2'd2:    byte_sel = word_cur[15:8];
         default: byte_sel = word_cur[7:0];
      endcase
   end

   assign c0_mixed      = comp_ff[0] ^ req_mix_word0;
   assign count_clamped = (req_byte_count > MAX_COUNT) ? MAX_COUNT : req_byte_count;
   assign idx           = left_ff - COUNT_W'(1);
   assign produced_sum  = {1'b0, produced_ff} + (PRODUCED_W+1)'(count_clamped);

   assign status.count_zero = (count_clamped == '0);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.last_step  = (left_ff == COUNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COMP; i++) begin
            comp_ff[i] <= '0;
         end
         produced_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.reseed) begin
            if (req_entropy_valid) begin
               comp_ff[0] <= c0_mixed ^ req_entropy0;
               comp_ff[1] <= comp_ff[1] ^ req_mix_word1 ^ c0_mixed ^ req_entropy1;
               comp_ff[2] <= comp_ff[2] ^ req_mix_word2 ^ c0_mixed ^ req_entropy2;
               comp_ff[3] <= comp_ff[3] ^ req_mix_word3 ^ c0_mixed ^ req_entropy3;
            end else begin
               comp_ff[0] <= c0_mixed;
               comp_ff[1] <= comp_ff[1] ^ req_mix_word1 ^ c0_mixed;
               comp_ff[2] <= comp_ff[2] ^ req_mix_word2 ^ c0_mixed;
               comp_ff[3] <= comp_ff[3] ^ req_mix_word3 ^ c0_mixed;
            end
            produced_ff <= '0;
         end else if (cmd.start) begin
            if (produced_sum[PRODUCED_W]) begin
               produced_ff <= PRODUCED_MAX;
            end else begin
               produced_ff <= produced_sum[PRODUCED_W-1:0];
            end
         end else if (cmd.step && (pos_ff == 2'd0)) begin
            for (int i = 0; i < NUM_COMP; i++) begin
               comp_ff[i] <= comp_step[i];
            end
         end
         if (cmd.step) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         left_ff <= count_clamped;
         pos_ff  <= 2'd0;
         due_ff  <= ({1'b0, limit} < produced_ff);
      end else if (cmd.step) begin
         left_ff <= idx;
         pos_ff  <= pos_ff + 2'd1;
         if (pos_ff == 2'd0) begin
            word_ff <= word_new;
         end
      end
      if (cmd.step) begin
         rsp_byte_value   <= byte_sel;
         rsp_buffer_index <= idx[INDEX_W-1:0];
         rsp_last_byte    <= (left_ff == COUNT_W'(1));
         rsp_reseed_due   <= due_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- hdl/tausworthe_byte_generator.sv -----
`default_nettype none
// Reseed requests take effect at the edge that accepts them; no result follows.
// A generate request of N bytes sends the controller to GEN, which steps each byte into
// the output register, one byte per cycle while the output is not stalled.
// The throughput is one byte per cycle without stalls, set by the single output register.
// Synchronous reset clears the components, the byte counter and the pending output.
module tausworthe_byte_generator
   import tbg_pkg::*;
#(
   parameter int MAX_REQUEST_BYTES = 64
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_func,
   input  wire logic [COUNT_W-1:0]    req_byte_count,
   input  wire logic [WORD_W-1:0]     req_mix_word0,
   input  wire logic [WORD_W-1:0]     req_mix_word1,
   input  wire logic [WORD_W-1:0]     req_mix_word2,
   input  wire logic [WORD_W-1:0]     req_mix_word3,
   input  wire logic [WORD_W-1:0]     req_entropy0,
   input  wire logic [WORD_W-1:0]     req_entropy1,
   input  wire logic [WORD_W-1:0]     req_entropy2,
   input  wire logic [WORD_W-1:0]     req_entropy3,
   input  wire logic                  req_entropy_valid,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [BYTE_W-1:0]          rsp_byte_value,
   output logic [INDEX_W-1:0]         rsp_buffer_index,
   output logic                       rsp_last_byte,
   output logic                       rsp_reseed_due,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   cmd_type             cmd;
   status_type          status;
   logic [LIMIT_W-1:0]  limit_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr == ADDR_LIMIT)) begin
         limit_ff <= csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_comb begin
      case (csr_paddr)
         ADDR_LIMIT: csr_prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, limit_ff};
         default:    csr_prdata = '0;
      endcase
   end

   tbg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   tbg_datapath #(
      .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_byte_count    (req_byte_count),
      .req_mix_word0     (req_mix_word0),
      .req_mix_word1     (req_mix_word1),
      .req_mix_word2     (req_mix_word2),
      .req_mix_word3     (req_mix_word3),
      .req_entropy0      (req_entropy0),
      .req_entropy1      (req_entropy1),
      .req_entropy2      (req_entropy2),
      .req_entropy3      (req_entropy3),
      .req_entropy_valid (req_entropy_valid),
      .limit             (limit_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_byte_value    (rsp_byte_value),
      .rsp_buffer_index  (rsp_buffer_index),
      .rsp_last_byte     (rsp_last_byte),
      .rsp_reseed_due    (rsp_reseed_due)
   );

endmodule

`default_nettype wire
